// File: sv/pxavg2x_pkg.sv
// Package for the 2x pixel-average upscaler: payload structs, register
// indexes, result kinds and the per-channel averaging function.
// No dependencies.
package pxavg2x_pkg;

  localparam int PIX_W  = 24;
  localparam int CHAN_W = 8;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  // Result kinds of one source pixel, emitted lowest first
  localparam int NUM_KINDS   = 4;
  localparam int KIND_INNER  = 0;  // block up and left
  localparam int KIND_UP_END = 1;  // block above, right column
  localparam int KIND_LEFT   = 2;  // block to the left, bottom row
  localparam int KIND_LAST   = 3;  // block of this pixel, last of frame

  typedef logic [NUM_KINDS-1:0] kind_mask_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] block_col;
    logic [ROW_W-1:0] block_row;
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
    logic             frame_end;
  } out_item_t;

  // floor((a+b)/2) on each 8-bit channel
  function automatic logic [PIX_W-1:0] avg_px(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0]  res;
    logic [CHAN_W:0]   sum;
    res = '0;
    for (int ch = 0; ch < PIX_W / CHAN_W; ch++) begin
      sum = {1'b0, a[ch*CHAN_W +: CHAN_W]} + {1'b0, b[ch*CHAN_W +: CHAN_W]};
      res[ch*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
    end
    return res;
  endfunction

endpackage

// File: sv/pxavg2x_ram.sv
// Generic single-port-write, single-port-read RAM with registered,
// read-before-write output. No dependencies.
module pxavg2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pixel_average_upscale_2x_unit.sv
// Top level of the 2x pixel-average upscaler. Uses pxavg2x_pkg, pxavg2x_ram.
// Path: an accepted pixel is registered in the work stage, and its blocks then go through the result register to out_.
// Throughput: one pixel per cycle while out_ready allows; a pixel that yields two
// to four blocks (right column, bottom row) holds the input until its last block
// is emitted, since the result register takes one block a cycle.
// Reset: counters, control and the edge pixels clear, width 640, height 480;
// the line store is not cleared.
module pixel_average_upscale_2x_unit
  import pxavg2x_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;

  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_cur_r;
  logic [AW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  kind_mask_t       s1_mask_r, mask_nxt;
  logic [PIX_W-1:0] above;

  logic [PIX_W-1:0] upper_left_r;
  logic [PIX_W-1:0] cur_left_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic             in_acc;
  logic [PIX_W-1:0] in_pix;
  logic [EW-1:0]    w_raw, w_eff, col_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] h_eff;
  logic             last_col, last_row, col_nz, row_nz;

  kind_mask_t pending, sel, mask_left;
  logic       out_free, emit, s1_retire;
  out_item_t  blk;
  logic [PIX_W-1:0] px_tl, px_right, px_below, px_diag, px_tr;
  logic [AW-1:0]    blk_col;
  logic [ROW_W-1:0] blk_row;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and the blocks it releases
  assign in_acc = in_valid && in_ready;
  assign in_pix = {in_data.red, in_data.green, in_data.blue};

  always_comb begin
    w_raw = EW'(width_r);
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff    = (height_r == '0) ? ROW_W'(1) : height_r;
    col_inc  = EW'(col_r) + EW'(1);
    row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= {1'b0, h_eff});
    col_nz   = (col_r != '0);
    row_nz   = (row_r != '0);

    mask_nxt              = '0;
    mask_nxt[KIND_INNER]  = row_nz && col_nz;
    mask_nxt[KIND_UP_END] = row_nz && last_col;
    mask_nxt[KIND_LEFT]   = last_row && col_nz;
    mask_nxt[KIND_LAST]   = last_row && last_col;

    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: read the pixel above and overwrite it with the current one
  pxavg2x_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (in_pix),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (above)
  );

  // Work stage: emit the pending blocks one a cycle while the result register is free, lowest kind first
  assign pending   = s1_valid_r ? s1_mask_r : '0;
  assign sel       = pending & (~pending + kind_mask_t'(1));
  assign mask_left = pending & ~sel;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (pending != '0) && out_free;
  assign s1_retire = s1_valid_r && ((s1_mask_r == '0) || (emit && mask_left == '0));
  assign in_ready  = !s1_valid_r || s1_retire;

  always_comb begin
    px_tl    = s1_cur_r;
    px_right = s1_cur_r;
    px_below = s1_cur_r;
    px_diag  = s1_cur_r;
    blk_col  = s1_col_r;
    blk_row  = s1_row_r;
    case (sel)
      kind_mask_t'(1 << KIND_INNER): begin
        px_tl    = upper_left_r;
        px_right = above;
        px_below = cur_left_r;
        px_diag  = s1_cur_r;
        blk_col  = s1_col_r - AW'(1);
        blk_row  = s1_row_r - ROW_W'(1);
      end
      kind_mask_t'(1 << KIND_UP_END): begin
        px_tl    = above;
        px_right = above;
        px_below = s1_cur_r;
        px_diag  = above;
        blk_row  = s1_row_r - ROW_W'(1);
      end
      kind_mask_t'(1 << KIND_LEFT): begin
        px_tl    = cur_left_r;
        px_right = s1_cur_r;
        px_below = cur_left_r;
        px_diag  = cur_left_r;
        blk_col  = s1_col_r - AW'(1);
      end
      default: ;
    endcase
    px_tr            = avg_px(px_tl, px_right);
    blk.block_col    = COL_W'(blk_col);
    blk.block_row    = blk_row;
    blk.top_left     = px_tl;
    blk.top_right    = px_tr;
    blk.bottom_left  = avg_px(px_tl, px_below);
    blk.bottom_right = avg_px(px_tr, avg_px(px_below, px_diag));
    blk.frame_end    = sel[KIND_LAST];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_mask_r  <= '0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      s1_mask_r  <= mask_nxt;
    end else if (s1_retire) begin
      s1_valid_r <= 1'b0;
    end else if (emit) begin
      s1_mask_r <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r <= in_pix;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // Advance the left-hand pixels as each request leaves the work stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_left_r <= '0;
      cur_left_r   <= '0;
    end else if (s1_retire) begin
      upper_left_r <= above;
      cur_left_r   <= s1_cur_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= blk;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
